// ===== hw/rtl/bba_pkg.sv =====
// shared types, codes and defaults of the bitmap block allocator
package bba_pkg;

  localparam int NUM_BLOCKS_DEF = 4096;
  localparam int WORD_BITS_DEF  = 32;

  localparam int OPCODE_W = 2;
  localparam int FIRST_W  = 12;
  localparam int END_W    = 13;
  localparam int STATUS_W = 3;
  localparam int FOUND_W  = 12;
  localparam int COUNT_W  = 13;

  // shift of the reciprocal used to split a block index into word and bit
  localparam int RECIP_SHIFT = END_W + 7;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FIND  = 2'd1,
    OP_FREE  = 2'd2
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_NOT_ENOUGH = 3'd1,
    ST_ALLOCATED  = 3'd2,
    ST_NONE_FREE  = 3'd3,
    ST_RANGE      = 3'd4
  } status_t;

  typedef struct packed {
    opcode_t              opcode;
    logic [FIRST_W-1:0]   first_index;
    logic [END_W-1:0]     end_index;
  } req_t;

  typedef struct packed {
    status_t              status;
    logic [FOUND_W-1:0]   found_index;
    logic [COUNT_W-1:0]   free_count;
  } rsp_t;

endpackage

// ===== hw/rtl/bba_if.sv =====
// request and response channel interfaces of the bitmap block allocator
interface bba_req_if;
  logic                          valid;
  logic                          ready;
  logic [bba_pkg::OPCODE_W-1:0]  opcode;
  logic [bba_pkg::FIRST_W-1:0]   first_index;
  logic [bba_pkg::END_W-1:0]     end_index;

  modport source (output valid, output opcode, output first_index, output end_index,
                  input ready);
  modport sink   (input valid, input opcode, input first_index, input end_index,
                  output ready);
endinterface

interface bba_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [bba_pkg::STATUS_W-1:0]  status;
  logic [bba_pkg::FOUND_W-1:0]   found_index;
  logic [bba_pkg::COUNT_W-1:0]   free_count;

  modport source (output valid, output status, output found_index, output free_count,
                  input ready);
  modport sink   (input valid, input status, input found_index, input free_count,
                  output ready);
endinterface

// ===== hw/rtl/bba_bitmap_ram.sv =====
// bitmap word memory, one write and one registered read port
module bba_bitmap_ram #(
  parameter  int DEPTH = bba_pkg::NUM_BLOCKS_DEF / bba_pkg::WORD_BITS_DEF,
  parameter  int WIDTH = bba_pkg::WORD_BITS_DEF,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/bba_engine.sv =====
// request sequencer: range checks, word scans and read-modify-write of the bitmap
module bba_engine #(
  parameter  int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF,
  parameter  int WORD_BITS  = bba_pkg::WORD_BITS_DEF,
  localparam int NWORDS     = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS,
  localparam int AW         = (NWORDS > 1) ? $clog2(NWORDS) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 req_valid,
  input  bba_pkg::req_t        req,
  output logic                 req_ready,
  output logic                 res_valid,
  output bba_pkg::rsp_t        res,
  input  logic                 res_ready,
  output logic                 rd_en,
  output logic [AW-1:0]        rd_addr,
  input  logic [WORD_BITS-1:0] rd_data,
  output logic                 wr_en,
  output logic [AW-1:0]        wr_addr,
  output logic [WORD_BITS-1:0] wr_data
);

  localparam int CW  = $clog2(NUM_BLOCKS + 1);
  localparam int XW0 = $clog2(NWORDS * WORD_BITS + 1);
  localparam int XW  = (XW0 > bba_pkg::END_W + 1) ? XW0 : bba_pkg::END_W + 1;
  localparam int OW  = $clog2(WORD_BITS + 1);
  localparam int PW  = $clog2(WORD_BITS);
  localparam int RK  = bba_pkg::RECIP_SHIFT;
  localparam logic [39:0] RM = 40'(((64'd1 << RK) + WORD_BITS - 1) / WORD_BITS);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_PREP, S_SCAN, S_RESP} state_t;

  state_t               state_r, state_nxt;
  logic [AW-1:0]        clr_r, clr_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  bba_pkg::opcode_t     op_r, op_nxt;
  logic                 set_r, set_nxt;
  logic [XW-1:0]        lo_r, lo_nxt, hi_r, hi_nxt;
  logic [AW-1:0]        qf_r, qf_nxt, ql_r, ql_nxt;
  logic [CW-1:0]        len_r, len_nxt;
  logic [AW:0]          ptr_r, ptr_nxt;
  logic [XW-1:0]        pbase_r, pbase_nxt, base0_r, base0_nxt;
  logic                 dv_r, dv_nxt;
  logic [AW-1:0]        dw_r, dw_nxt;
  logic [XW-1:0]        dbase_r, dbase_nxt;
  logic [WORD_BITS-1:0] dmask_r, dmask_nxt;
  bba_pkg::rsp_t        res_r, res_nxt;

  logic [XW-1:0]        first_x, end_x, nb_x, len_x, lo_d, hi_d;
  logic [bba_pkg::END_W-1:0] end_m1;
  logic [39:0]          prod_f, prod_l;
  logic [OW-1:0]        lo_off, hi_off;
  logic [WORD_BITS-1:0] imask, used_bits, free_bits, iso;
  logic [PW-1:0]        pos;
  logic                 issue, last, used_any, free_any;
  logic [CW-1:0]        cnt_inc;

  // request decode and word split by reciprocal multiply
  always_comb begin
    first_x = XW'(req.first_index);
    end_x   = XW'(req.end_index);
    nb_x    = XW'(NUM_BLOCKS);
    len_x   = end_x - first_x;
    end_m1  = req.end_index - 1'b1;
    prod_f  = 40'(req.first_index) * RM;
    prod_l  = 40'(end_m1) * RM;
  end

  // mask of the word being issued, from the range bounds
  always_comb begin
    lo_d = lo_r - pbase_r;
    hi_d = hi_r - pbase_r;
    if (lo_r <= pbase_r) begin
      lo_off = '0;
    end else if (lo_d >= XW'(WORD_BITS)) begin
      lo_off = OW'(WORD_BITS);
    end else begin
      lo_off = OW'(lo_d);
    end
    if (hi_r <= pbase_r) begin
      hi_off = '0;
    end else if (hi_d >= XW'(WORD_BITS)) begin
      hi_off = OW'(WORD_BITS);
    end else begin
      hi_off = OW'(hi_d);
    end
    for (int i = 0; i < WORD_BITS; i++) begin
      imask[i] = (OW'(i) >= lo_off) && (OW'(i) < hi_off);
    end
  end

  // evaluation of the word returned by the memory
  always_comb begin
    used_bits = rd_data & dmask_r;
    free_bits = ~rd_data & dmask_r;
    used_any  = |used_bits;
    free_any  = |free_bits;
    iso       = free_bits & (~free_bits + 1'b1);
    pos       = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (iso[i]) begin
        pos = pos | PW'(i);
      end
    end
    last    = (dw_r == ql_r);
    issue   = (ptr_r <= {1'b0, ql_r});
    cnt_inc = used_any ? cnt_r + 1'b1 : cnt_r;
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    cnt_nxt   = cnt_r;
    op_nxt    = op_r;
    set_nxt   = set_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    qf_nxt    = qf_r;
    ql_nxt    = ql_r;
    len_nxt   = len_r;
    ptr_nxt   = ptr_r;
    pbase_nxt = pbase_r;
    base0_nxt = base0_r;
    dv_nxt    = 1'b0;
    dw_nxt    = dw_r;
    dbase_nxt = dbase_r;
    dmask_nxt = dmask_r;
    res_nxt   = res_r;
    rd_en     = 1'b0;
    rd_addr   = ptr_r[AW-1:0];
    wr_en     = 1'b0;
    wr_addr   = dw_r;
    wr_data   = rd_data;
    req_ready = 1'b0;
    res_valid = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(NWORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          op_nxt              = req.opcode;
          set_nxt             = 1'b0;
          res_nxt.found_index = '0;
          res_nxt.free_count  = bba_pkg::COUNT_W'(cnt_r);
          res_nxt.status      = bba_pkg::ST_OK;
          unique case (req.opcode)
            bba_pkg::OP_ALLOC: begin
              lo_nxt  = first_x;
              hi_nxt  = end_x;
              qf_nxt  = prod_f[RK +: AW];
              ql_nxt  = prod_l[RK +: AW];
              len_nxt = CW'(len_x);
              if (end_x < first_x || first_x >= nb_x || end_x > nb_x) begin
                res_nxt.status = bba_pkg::ST_RANGE;
                state_nxt      = S_RESP;
              end else if (XW'(cnt_r) < len_x) begin
                res_nxt.status = bba_pkg::ST_NOT_ENOUGH;
                state_nxt      = S_RESP;
              end else if (len_x == '0) begin
                state_nxt = S_RESP;
              end else begin
                state_nxt = S_PREP;
              end
            end
            bba_pkg::OP_FIND: begin
              lo_nxt    = '0;
              hi_nxt    = nb_x;
              qf_nxt    = '0;
              ql_nxt    = AW'(NWORDS - 1);
              state_nxt = S_PREP;
            end
            bba_pkg::OP_FREE: begin
              lo_nxt = first_x;
              hi_nxt = first_x + 1'b1;
              qf_nxt = prod_f[RK +: AW];
              ql_nxt = prod_f[RK +: AW];
              if (first_x >= nb_x) begin
                res_nxt.status = bba_pkg::ST_RANGE;
                state_nxt      = S_RESP;
              end else begin
                state_nxt = S_PREP;
              end
            end
            default: begin
              res_nxt.status = bba_pkg::ST_RANGE;
              state_nxt      = S_RESP;
            end
          endcase
        end
      end

      S_PREP: begin
        pbase_nxt = XW'(qf_r) * XW'(WORD_BITS);
        base0_nxt = XW'(qf_r) * XW'(WORD_BITS);
        ptr_nxt   = {1'b0, qf_r};
        state_nxt = S_SCAN;
      end

      S_SCAN: begin
        rd_en = issue;
        if (issue) begin
          ptr_nxt   = ptr_r + 1'b1;
          pbase_nxt = pbase_r + XW'(WORD_BITS);
          dv_nxt    = 1'b1;
          dw_nxt    = ptr_r[AW-1:0];
          dbase_nxt = pbase_r;
          dmask_nxt = imask;
        end
        if (dv_r) begin
          case (op_r)
            bba_pkg::OP_ALLOC: begin
              if (!set_r) begin
                if (used_any) begin
                  res_nxt.status = bba_pkg::ST_ALLOCATED;
                  state_nxt      = S_RESP;
                  dv_nxt         = 1'b0;
                end else if (last) begin
                  // range is clear, sweep it again to mark it
                  set_nxt   = 1'b1;
                  ptr_nxt   = {1'b0, qf_r};
                  pbase_nxt = base0_r;
                  dv_nxt    = 1'b0;
                end
              end else begin
                wr_en   = 1'b1;
                wr_data = rd_data | dmask_r;
                if (last) begin
                  cnt_nxt            = cnt_r - len_r;
                  res_nxt.free_count = bba_pkg::COUNT_W'(cnt_r - len_r);
                  state_nxt          = S_RESP;
                  dv_nxt             = 1'b0;
                end
              end
            end
            bba_pkg::OP_FIND: begin
              if (free_any) begin
                res_nxt.found_index = bba_pkg::FOUND_W'(dbase_r + XW'(pos));
                state_nxt           = S_RESP;
                dv_nxt              = 1'b0;
              end else if (last) begin
                res_nxt.status = bba_pkg::ST_NONE_FREE;
                state_nxt      = S_RESP;
                dv_nxt         = 1'b0;
              end
            end
            bba_pkg::OP_FREE: begin
              wr_en              = used_any;
              wr_data            = rd_data & ~dmask_r;
              cnt_nxt            = cnt_inc;
              res_nxt.free_count = bba_pkg::COUNT_W'(cnt_inc);
              state_nxt          = S_RESP;
              dv_nxt             = 1'b0;
            end
            default: begin
              res_nxt.status = bba_pkg::ST_RANGE;
              state_nxt      = S_RESP;
              dv_nxt         = 1'b0;
            end
          endcase
        end
      end

      S_RESP: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      cnt_r   <= CW'(NUM_BLOCKS);
      dv_r    <= 1'b0;
      set_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      cnt_r   <= cnt_nxt;
      dv_r    <= dv_nxt;
      set_r   <= set_nxt;
    end
    op_r    <= op_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    qf_r    <= qf_nxt;
    ql_r    <= ql_nxt;
    len_r   <= len_nxt;
    ptr_r   <= ptr_nxt;
    pbase_r <= pbase_nxt;
    base0_r <= base0_nxt;
    dw_r    <= dw_nxt;
    dbase_r <= dbase_nxt;
    dmask_r <= dmask_nxt;
    res_r   <= res_nxt;
  end

  assign res = res_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(NUM_BLOCKS))
    else $error("free counter above block count");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_en && wr_en && rd_addr == wr_addr))
    else $error("read and write of the same bitmap word in one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req_valid && req_ready |=> state_r != S_IDLE)
    else $error("accepted request did not start");

  a_data_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    dv_r |-> state_r == S_SCAN)
    else $error("memory word in flight outside a scan");

endmodule

// ===== hw/rtl/bitmap_block_allocator.sv =====
// top level of the bitmap block allocator
// one used/free bit per block, packed WORD_BITS to a word in a single-port-read
// bitmap memory, plus a free-block counter. after reset the block sweeps the
// memory to zero, one word a cycle, and takes no request meanwhile. one request
// is worked at a time; the memory read port moves one word per cycle, so the
// cost follows the words touched: a rejected or empty range reads no word, a
// free reads one, find-first-free reads words until it meets a free block, and
// a successful allocation reads each word of its range twice (the range is
// checked in one sweep and marked in a second). a refused allocation changes
// nothing. the response sits in an output register, so the next request is
// taken while an earlier response still waits on out_rsp.ready
module bitmap_block_allocator #(
  parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF,
  parameter int WORD_BITS  = bba_pkg::WORD_BITS_DEF
) (
  input logic         clk,
  input logic         rst_n,
  bba_req_if.sink     in_req,
  bba_rsp_if.source   out_rsp
);

  localparam int NWORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;

  bba_pkg::req_t        req;
  bba_pkg::rsp_t        eng_res;
  logic                 eng_res_valid;
  logic                 eng_res_ready;
  logic                 eng_req_ready;

  // bitmap memory ports
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [WORD_BITS-1:0] rd_data;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  // output register
  logic                 out_valid_r;
  bba_pkg::rsp_t        out_data_r;

  // request payload into the engine's struct
  always_comb begin
    req.opcode      = bba_pkg::opcode_t'(in_req.opcode);
    req.first_index = in_req.first_index;
    req.end_index   = in_req.end_index;
  end

  assign in_req.ready = eng_req_ready;

  bba_bitmap_ram #(
    .DEPTH (NWORDS),
    .WIDTH (WORD_BITS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bba_engine #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .WORD_BITS  (WORD_BITS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_req.valid),
    .req       (req),
    .req_ready (eng_req_ready),
    .res_valid (eng_res_valid),
    .res       (eng_res),
    .res_ready (eng_res_ready),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  // slot is free when empty or being drained this cycle
  assign eng_res_ready = !out_valid_r || out_rsp.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (eng_res_valid && eng_res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
    if (eng_res_valid && eng_res_ready) begin
      out_data_r <= eng_res;
    end
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.status      = out_data_r.status;
  assign out_rsp.found_index = out_data_r.found_index;
  assign out_rsp.free_count  = out_data_r.free_count;

endmodule

// ===== dv/bitmap_block_allocator_test.sv =====
`timescale 1ns / 100ps
// self-checking testbench of the bitmap block allocator: directed table, then random requests
module bitmap_block_allocator_test;

  localparam int N_BLOCKS     = bba_pkg::NUM_BLOCKS_DEF;
  localparam int RANDOM_REQS  = 1700;
  localparam int LIMIT_CYCLES = 4_000_000;
  // cycles to wait after the last response; covers a full-bitmap scan
  localparam int DRAIN_CYCLES = 300;
  // opcode that the block does not define
  localparam logic [bba_pkg::OPCODE_W-1:0] OP_UNKNOWN = 2'd3;

  // one row of the directed table; the expected response only counts when pinned is set
  typedef struct packed {
    logic [bba_pkg::OPCODE_W-1:0] op;
    logic [bba_pkg::FIRST_W-1:0]  first;
    logic [bba_pkg::END_W-1:0]    last_end;
    bit                           pinned;
    bba_pkg::status_t             status;
    logic [bba_pkg::FOUND_W-1:0]  found;
    logic [bba_pkg::COUNT_W-1:0]  count;
  } dir_row_t;

  localparam int DIR_ROWS_N = 26;
  localparam dir_row_t DIR_ROWS [DIR_ROWS_N] = '{
    // fresh bitmap: lowest free block is zero, counter at full
    '{bba_pkg::OP_FIND,  12'd0,    13'd0,    1'b1, bba_pkg::ST_OK,         12'd0, 13'd4096},
    // empty range succeeds and changes nothing
    '{bba_pkg::OP_ALLOC, 12'd0,    13'd0,    1'b1, bba_pkg::ST_OK,         12'd0, 13'd4096},
    // end below first
    '{bba_pkg::OP_ALLOC, 12'd10,   13'd5,    1'b1, bba_pkg::ST_RANGE,      12'd0, 13'd4096},
    // end one past the bitmap
    '{bba_pkg::OP_ALLOC, 12'd0,    13'd4097, 1'b1, bba_pkg::ST_RANGE,      12'd0, 13'd4096},
    // all-ones fields
    '{bba_pkg::OP_ALLOC, 12'd4095, 13'd8191, 1'b1, bba_pkg::ST_RANGE,      12'd0, 13'd4096},
    '{OP_UNKNOWN,        12'd4095, 13'd8191, 1'b1, bba_pkg::ST_RANGE,      12'd0, 13'd4096},
    // freeing a free block leaves the counter alone
    '{bba_pkg::OP_FREE,  12'd4095, 13'd0,    1'b1, bba_pkg::ST_OK,         12'd0, 13'd4096},
    // exact fit of the whole bitmap
    '{bba_pkg::OP_ALLOC, 12'd0,    13'd4096, 1'b1, bba_pkg::ST_OK,         12'd0, 13'd0},
    '{bba_pkg::OP_FIND,  12'd0,    13'd0,    1'b1, bba_pkg::ST_NONE_FREE,  12'd0, 13'd0},
    '{bba_pkg::OP_ALLOC, 12'd4095, 13'd4096, 1'b1, bba_pkg::ST_NOT_ENOUGH, 12'd0, 13'd0},
    // empty range with nothing free still succeeds
    '{bba_pkg::OP_ALLOC, 12'd7,    13'd7,    1'b1, bba_pkg::ST_OK,         12'd0, 13'd0},
    '{bba_pkg::OP_FREE,  12'd4095, 13'd0,    1'b1, bba_pkg::ST_OK,         12'd0, 13'd1},
    '{bba_pkg::OP_FREE,  12'd2730, 13'd0,    1'b1, bba_pkg::ST_OK,         12'd0, 13'd2},
    '{bba_pkg::OP_FREE,  12'd1365, 13'd0,    1'b1, bba_pkg::ST_OK,         12'd0, 13'd3},
    // from here the predictor supplies the expectation
    '{bba_pkg::OP_FIND,  12'd0,    13'd0,    1'b0, bba_pkg::ST_OK,         12'd0, 13'd0},
    '{bba_pkg::OP_ALLOC, 12'd1365, 13'd1367, 1'b0, bba_pkg::ST_OK,         12'd0, 13'd0},
    '{bba_pkg::OP_ALLOC, 12'd2730, 13'd2734, 1'b0, bba_pkg::ST_OK,         12'd0, 13'd0},
    '{bba_pkg::OP_ALLOC, 12'd2730, 13'd2733, 1'b0, bba_pkg::ST_OK,         12'd0, 13'd0},
    '{bba_pkg::OP_FREE,  12'd2731, 13'd0,    1'b0, bba_pkg::ST_OK,         12'd0, 13'd0},
    '{bba_pkg::OP_FREE,  12'd2732, 13'd0,    1'b0, bba_pkg::ST_OK,         12'd0, 13'd0},
    '{bba_pkg::OP_ALLOC, 12'd2730, 13'd2733, 1'b0, bba_pkg::ST_OK,         12'd0, 13'd0},
    '{bba_pkg::OP_ALLOC, 12'd4095, 13'd4096, 1'b0, bba_pkg::ST_OK,         12'd0, 13'd0},
    '{bba_pkg::OP_FIND,  12'd0,    13'd0,    1'b0, bba_pkg::ST_OK,         12'd0, 13'd0},
    '{bba_pkg::OP_FREE,  12'd0,    13'd0,    1'b0, bba_pkg::ST_OK,         12'd0, 13'd0},
    '{bba_pkg::OP_FIND,  12'd0,    13'd0,    1'b0, bba_pkg::ST_OK,         12'd0, 13'd0},
    '{bba_pkg::OP_ALLOC, 12'd0,    13'd4096, 1'b0, bba_pkg::ST_OK,         12'd0, 13'd0}
  };

  logic clk;
  logic rst_n;

  bba_req_if req_ch();
  bba_rsp_if rsp_ch();

  bitmap_block_allocator uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch.sink),
    .out_rsp (rsp_ch.source)
  );

  // shadow copy of the block state
  bit          used_map [N_BLOCKS];
  int unsigned free_left;

  bba_pkg::rsp_t pending_rsp [$];
  int            err_count = 0;
  int unsigned   cycle_count = 0;
  // no idling on either side while set
  bit            steady_flow;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  task automatic report_mismatch(string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    err_count++;
  endtask

  // computes the response to one request and applies it to the shadow state
  function automatic bba_pkg::rsp_t predict_rsp(logic [bba_pkg::OPCODE_W-1:0] op,
                                                logic [bba_pkg::FIRST_W-1:0] first,
                                                logic [bba_pkg::END_W-1:0] last_end);
    bba_pkg::rsp_t r;
    int unsigned   span;
    bit            clash;
    r.status      = bba_pkg::ST_OK;
    r.found_index = '0;
    case (op)
      bba_pkg::OP_ALLOC: begin
        if (last_end < first || first >= N_BLOCKS || last_end > N_BLOCKS) begin
          r.status = bba_pkg::ST_RANGE;
        end else begin
          span = 32'(last_end - first);
          // exact fit is allowed
          if (free_left < span) begin
            r.status = bba_pkg::ST_NOT_ENOUGH;
          end else begin
            clash = 1'b0;
            for (int n = int'(first); n < int'(last_end); n++) if (used_map[n]) clash = 1'b1;
            if (clash) begin
              r.status = bba_pkg::ST_ALLOCATED;
            end else begin
              for (int n = int'(first); n < int'(last_end); n++) used_map[n] = 1'b1;
              free_left -= span;
            end
          end
        end
      end
      bba_pkg::OP_FIND: begin
        r.status = bba_pkg::ST_NONE_FREE;
        for (int n = 0; n < N_BLOCKS; n++) begin
          if (!used_map[n]) begin
            r.status      = bba_pkg::ST_OK;
            r.found_index = n[bba_pkg::FOUND_W-1:0];
            break;
          end
        end
      end
      bba_pkg::OP_FREE: begin
        if (first >= N_BLOCKS) begin
          r.status = bba_pkg::ST_RANGE;
        end else if (used_map[first]) begin
          used_map[first] = 1'b0;
          free_left++;
        end
      end
      default: r.status = bba_pkg::ST_RANGE;
    endcase
    r.free_count = free_left[bba_pkg::COUNT_W-1:0];
    return r;
  endfunction

  // presents one request, waits for its handshake and queues the expected response;
  // called at a rising edge, returns at the edge of acceptance
  task automatic send_req(logic [bba_pkg::OPCODE_W-1:0] op,
                          logic [bba_pkg::FIRST_W-1:0] first,
                          logic [bba_pkg::END_W-1:0] last_end, bit pinned,
                          bba_pkg::rsp_t pinned_rsp);
    bba_pkg::rsp_t predicted;
    if (!steady_flow && $urandom_range(99) < 30) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.opcode      <= op;
    req_ch.first_index <= first;
    req_ch.end_index   <= last_end;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predicted = predict_rsp(op, first, last_end);
    pending_rsp.push_back(pinned ? pinned_rsp : predicted);
  endtask

  // hold the sender until every queued response is back
  task automatic wait_all_back();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  // response side back-pressure
  always @(posedge clk) begin
    rsp_ch.ready <= steady_flow || ($urandom_range(99) >= 30);
  end

  // response checker
  always @(posedge clk) begin
    bba_pkg::rsp_t want;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch($sformatf("response with nothing pending, status %0d",
                                  rsp_ch.status));
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_ch.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", rsp_ch.status, want.status));
        if (rsp_ch.found_index !== want.found_index)
          report_mismatch($sformatf("found_index got %0d want %0d",
                                    rsp_ch.found_index, want.found_index));
        if (rsp_ch.free_count !== want.free_count)
          report_mismatch($sformatf("free_count got %0d want %0d",
                                    rsp_ch.free_count, want.free_count));
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    bba_pkg::rsp_t                pinned_rsp;
    bba_pkg::rsp_t                no_rsp;
    int                           kind;
    int                           start;
    int                           run;
    int                           span;
    int                           pick;
    bit                           fill_phase;
    logic [bba_pkg::OPCODE_W-1:0] op;
    logic [bba_pkg::FIRST_W-1:0]  first;
    logic [bba_pkg::END_W-1:0]    last_end;

    steady_flow  = 1'b0;
    no_rsp       = '0;
    rst_n        <= 1'b0;
    req_ch.valid       <= 1'b0;
    req_ch.opcode      <= bba_pkg::OP_FIND;
    req_ch.first_index <= '0;
    req_ch.end_index   <= '0;

    // shadow state after reset: every block free
    foreach (used_map[n]) used_map[n] = 1'b0;
    free_left = N_BLOCKS;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int i = 0; i < DIR_ROWS_N; i++) begin
      pinned_rsp.status      = DIR_ROWS[i].status;
      pinned_rsp.found_index = DIR_ROWS[i].found;
      pinned_rsp.free_count  = DIR_ROWS[i].count;
      send_req(DIR_ROWS[i].op, DIR_ROWS[i].first, DIR_ROWS[i].last_end,
               DIR_ROWS[i].pinned, pinned_rsp);
    end
    wait_all_back();

    // random part: alternating fill and drain phases over the shadow bitmap
    for (int i = 0; i < RANDOM_REQS; i++) begin
      if (i == 500) wait_all_back();
      steady_flow = (i >= 800 && i < 1100);
      fill_phase  = (i % 400) < 140;
      kind        = $urandom_range(99);
      op          = bba_pkg::OP_FIND;
      first       = '0;
      last_end    = '0;

      if (kind < 10) begin
        // noise: any opcode, any field value
        op       = 2'($urandom_range(3));
        first    = 12'($urandom_range(4095));
        last_end = 13'($urandom_range(8191));
      end else if (kind < (fill_phase ? 60 : 25)) begin
        // allocation starting at a free block, mostly sized to fit its free run
        start = -1;
        pick  = $urandom_range(N_BLOCKS - 1);
        for (int n = pick; n < N_BLOCKS && start < 0; n++) if (!used_map[n]) start = n;
        for (int n = 0; n < pick && start < 0; n++) if (!used_map[n]) start = n;
        if (start < 0) start = $urandom_range(N_BLOCKS - 1);
        run = 0;
        while (start + run < N_BLOCKS && !used_map[start + run]) run++;
        span = ($urandom_range(49) == 0) ? $urandom_range(1, N_BLOCKS)
                                         : $urandom_range(1, 48);
        if (run > 0 && $urandom_range(99) < 70 && span > run) span = run;
        if (start + span > N_BLOCKS) span = N_BLOCKS - start;
        op       = bba_pkg::OP_ALLOC;
        first    = 12'(start);
        last_end = 13'(start + span);
      end else if (kind < (fill_phase ? 75 : 35)) begin
        op = bba_pkg::OP_FIND;
      end else begin
        // free, aimed at a used block when one turns up
        pick = $urandom_range(N_BLOCKS - 1);
        for (int t = 0; t < 16 && !used_map[pick]; t++) pick = $urandom_range(N_BLOCKS - 1);
        op       = bba_pkg::OP_FREE;
        first    = 12'(pick);
        last_end = 13'($urandom_range(8191));
      end
      send_req(op, first, last_end, 1'b0, no_rsp);
    end
    steady_flow = 1'b0;

    req_ch.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0 && pending_rsp.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/bba_pkg.sv
hw/rtl/bba_if.sv
hw/rtl/bba_bitmap_ram.sv
hw/rtl/bba_engine.sv
hw/rtl/bitmap_block_allocator.sv
dv/bitmap_block_allocator_test.sv
